// ===== rtl/tmid_pkg.sv =====
// ----------------------------------------------------------------------------
// tmid_pkg
// Types, codes and constants shared by the tune event to MIDI stream block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tmid_pkg;

  // source parser phase
  typedef enum logic [2:0] {
    PH_DELTA,
    PH_EVENT,
    PH_VEL,
    PH_ARG1,
    PH_ARG2
  } phase_t;

  // controller states; the emitting states double as output segment select
  typedef enum logic [2:0] {
    C_IDLE,
    C_PLAN,
    C_DIV,
    C_TEMPO,
    C_FLUSH1,
    C_EVT,
    C_FLUSH2,
    C_END
  } ctrl_state_t;

  // source command codes
  localparam logic [7:0] CMD_NOTE_OFF   = 8'h90;
  localparam logic [7:0] CMD_TRACK_END  = 8'h91;
  localparam logic [7:0] CMD_PROGRAM    = 8'h92;
  localparam logic [7:0] CMD_BEND       = 8'h95;
  localparam logic [7:0] CMD_VOLUME     = 8'h96;
  localparam logic [7:0] CMD_DRUM       = 8'h97;
  localparam logic [7:0] CMD_LOOP_BACK  = 8'h98;
  localparam logic [7:0] CMD_LAST_OFF   = 8'h99;
  localparam logic [7:0] CMD_PAN        = 8'h9B;
  localparam logic [7:0] CMD_LOOP_START = 8'h9C;
  localparam logic [7:0] CMD_CTRL       = 8'h9D;
  localparam logic [3:0] CHAN_SEL_HI    = 4'h8;

  // MIDI status nibbles and controller numbers
  localparam logic [3:0] STAT_NOTE    = 4'h9;
  localparam logic [3:0] STAT_PROGRAM = 4'hC;
  localparam logic [3:0] STAT_BEND    = 4'hE;
  localparam logic [3:0] STAT_CTRL    = 4'hB;
  localparam logic [7:0] CC_VOLUME    = 8'h07;
  localparam logic [7:0] CC_DRUM      = 8'h67;
  localparam logic [7:0] CC_PAN       = 8'h0A;

  // meta events
  localparam logic [7:0] META           = 8'hFF;
  localparam logic [7:0] META_TEMPO     = 8'h51;
  localparam logic [7:0] META_TEMPO_LEN = 8'h03;
  localparam logic [7:0] META_EOT       = 8'h2F;

  localparam logic [7:0]  NO_NOTE       = 8'hFF;
  localparam logic [7:0]  TEMPO_DEFAULT = 8'd120;
  localparam logic [23:0] LEN_MAX       = 24'hFFFFFF;

  // tempo division: microseconds per minute over bpm
  localparam int                    DIV_BITS       = 26;
  localparam int                    DIV_CNT_W      = $clog2(DIV_BITS);
  localparam logic [DIV_BITS-1:0]   TEMPO_DIVIDEND = 26'd60000000;

  // output segment sizes
  localparam int EVT_MAX = 7;
  localparam int POS_W   = 3;
  localparam logic [POS_W-1:0] TEMPO_LAST = 3'd6;
  localparam logic [POS_W-1:0] END_LAST   = 3'd2;

  typedef struct packed {
    logic        accept;
    logic        div_step;
    logic        emit;
    logic        pos_clr;
    logic        last;
    ctrl_state_t seg;
  } ctrl_cmd_t;

  typedef struct packed {
    logic tempo_en;
    logic flush1_en;
    logic evt_en;
    logic close_en;
    logic div_last;
    logic seg_final;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/tmid_in_if.sv =====
// ----------------------------------------------------------------------------
// tmid_in_if
// Source byte channel: valid/ready plus one source byte and its markers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tmid_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       track_start;
  logic       first_track;
  logic       source_last;

  modport source (
    output valid, in_byte, track_start, first_track, source_last,
    input  ready
  );

  modport sink (
    input  valid, in_byte, track_start, first_track, source_last,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/tmid_out_if.sv =====
// ----------------------------------------------------------------------------
// tmid_out_if
// Track body channel: valid/ready plus one output byte and its status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tmid_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        last_of_run;
  logic        track_done;
  logic [23:0] body_length;
  logic        bad_command;

  modport source (
    output valid, out_byte, last_of_run, track_done, body_length, bad_command,
    input  ready
  );

  modport sink (
    input  valid, out_byte, last_of_run, track_done, body_length, bad_command,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/tune_event_to_midi_stream.sv =====
// ----------------------------------------------------------------------------
// tune_event_to_midi_stream
// Converts compact tune track-event bytes into a standard MIDI track body.
//
// Usage:
//   in_s  : one source byte per beat with track_start, first_track and
//           source_last markers. Ready is high only while the block is idle.
//   out_s : track body bytes, one per beat, with last_of_run on the final
//           byte caused by a source byte, track_done on the final byte of
//           the end-of-track event, running body_length and bad_command.
//   cfg_  : cfg_we writes cfg_data into the tempo register (bpm).
//   Timing: an accepted beat is decoded as it is taken and passes the plan
//   state, then writes its N output bytes (0 to 16) one per cycle into the
//   output register while the receiver takes them. A track start with
//   first_track set adds the bit-serial tempo division before them.
//   A source byte with no output leaves ready low for one cycle only.
//   The next beat is accepted while the last output byte still waits.
//   Receiver stall: the output register holds its byte and the sequencer
//   waits; no byte is lost or repeated.
//   Reset: rst_n is synchronous; tempo returns to 120 and the parser state
//   returns to a fresh track without tempo.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tune_event_to_midi_stream (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        cfg_we,
  input  wire  [7:0] cfg_data,
  tmid_in_if.sink    in_s,
  tmid_out_if.source out_s
);

  tmid_pkg::ctrl_cmd_t  cmd;
  tmid_pkg::dp_status_t st;
  logic                 in_ready;

  tmid_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_s.valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  tmid_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .in_byte         (in_s.in_byte),
    .in_track_start  (in_s.track_start),
    .in_first_track  (in_s.first_track),
    .in_source_last  (in_s.source_last),
    .out_ready       (out_s.ready),
    .out_valid       (out_s.valid),
    .out_byte        (out_s.out_byte),
    .out_last_of_run (out_s.last_of_run),
    .out_track_done  (out_s.track_done),
    .out_body_length (out_s.body_length),
    .out_bad_command (out_s.bad_command),
    .cmd             (cmd),
    .st              (st)
  );

  assign in_s.ready = in_ready;

`ifndef SYNTH
  // end-of-track byte always ends its run
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_s.valid && out_s.track_done |-> out_s.last_of_run)
    else $error("track_done without last_of_run");

  // a bad-command run only ends on the end-of-track byte
  a_bad_ends_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_s.valid && out_s.bad_command && out_s.last_of_run |-> out_s.track_done)
    else $error("bad_command run ended before end of track");

  // block is busy in the plan state after an accepted beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_s.valid && in_s.ready |=> !in_s.ready)
    else $error("ready high right after accept");

  // body length is nonzero after a body byte outside the tempo segment
  a_len_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit && !cmd.accept && (cmd.seg != tmid_pkg::C_TEMPO) |=>
      out_s.body_length != 24'd0)
    else $error("body length zero after a body byte");
`endif

endmodule

`default_nettype wire

// ===== rtl/tmid_ctrl.sv =====
// ----------------------------------------------------------------------------
// tmid_ctrl
// Sequencer: accepts a source beat, runs the tempo division when needed and
// steps the datapath through the output segments one byte per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tmid_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  tmid_pkg::dp_status_t st,
  output tmid_pkg::ctrl_cmd_t  cmd
);

  tmid_pkg::ctrl_state_t state_r;
  tmid_pkg::ctrl_state_t state_nxt;
  tmid_pkg::ctrl_state_t follow;
  tmid_pkg::ctrl_state_t after_tempo;
  tmid_pkg::ctrl_state_t after_evt;
  logic                  emit_seg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tmid_pkg::C_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    after_evt   = st.close_en ? tmid_pkg::C_FLUSH2 : tmid_pkg::C_IDLE;
    after_tempo = st.flush1_en ? tmid_pkg::C_FLUSH1 :
                  st.evt_en    ? tmid_pkg::C_EVT    : after_evt;
    state_nxt   = state_r;
    follow      = tmid_pkg::C_IDLE;
    emit_seg    = 1'b0;
    in_ready    = 1'b0;
    cmd         = '0;
    cmd.seg     = state_r;
    unique case (state_r)
      tmid_pkg::C_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = tmid_pkg::C_PLAN;
        end
      end
      tmid_pkg::C_PLAN: begin
        state_nxt = st.tempo_en ? tmid_pkg::C_DIV : after_tempo;
      end
      tmid_pkg::C_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) begin
          state_nxt = tmid_pkg::C_TEMPO;
        end
      end
      tmid_pkg::C_TEMPO: begin
        emit_seg = 1'b1;
        follow   = after_tempo;
      end
      tmid_pkg::C_FLUSH1: begin
        emit_seg = 1'b1;
        follow   = tmid_pkg::C_EVT;
      end
      tmid_pkg::C_EVT: begin
        emit_seg = 1'b1;
        follow   = after_evt;
      end
      tmid_pkg::C_FLUSH2: begin
        emit_seg = 1'b1;
        follow   = tmid_pkg::C_END;
      end
      tmid_pkg::C_END: begin
        emit_seg = 1'b1;
        follow   = tmid_pkg::C_IDLE;
      end
      default: begin
        state_nxt = tmid_pkg::C_IDLE;
      end
    endcase

    if (emit_seg && st.out_free) begin
      cmd.emit = 1'b1;
      if (st.seg_final) begin
        cmd.pos_clr = 1'b1;
        cmd.last    = (follow == tmid_pkg::C_IDLE);
        state_nxt   = follow;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tmid_dp.sv =====
// ----------------------------------------------------------------------------
// tmid_dp
// Datapath: parser state, event decode, tempo divider, VLQ delta writer,
// byte counter and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tmid_dp (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  cfg_we,
  input  wire  [7:0]           cfg_data,
  input  wire  [7:0]           in_byte,
  input  wire                  in_track_start,
  input  wire                  in_first_track,
  input  wire                  in_source_last,
  input  wire                  out_ready,
  output logic                 out_valid,
  output logic [7:0]           out_byte,
  output logic                 out_last_of_run,
  output logic                 out_track_done,
  output logic [23:0]          out_body_length,
  output logic                 out_bad_command,
  input  tmid_pkg::ctrl_cmd_t  cmd,
  output tmid_pkg::dp_status_t st
);

  localparam int PW = tmid_pkg::POS_W;
  localparam int DW = tmid_pkg::DIV_CNT_W;
  localparam int QW = tmid_pkg::DIV_BITS;

  // architectural parser state
  logic [7:0]       tempo_r;
  tmid_pkg::phase_t phase_r;
  logic [31:0]      accum_r;
  logic [31:0]      pend_r;
  logic [3:0]       chan_r;
  logic [7:0]       prev_note_r;
  logic [7:0]       hcmd_r;
  logic [7:0]       harg_r;
  logic             closed_r;
  logic [23:0]      count_r;

  // plan for the current beat
  logic             tempo_en_r;
  logic             flush1_r;
  logic             close_r;
  logic             bad_r;
  logic [PW-1:0]    evt_len_r;
  logic [7:0]       evt_r [tmid_pkg::EVT_MAX];
  logic [PW-1:0]    pos_r;

  // tempo divider
  logic [DW-1:0]    div_cnt_r;
  logic [7:0]       rem_r;
  logic [QW-1:0]    quo_r;

  // output register
  logic             out_valid_r;
  logic [7:0]       out_byte_r;
  logic             out_last_r;
  logic             out_done_r;
  logic [23:0]      out_len_r;
  logic             out_bad_r;

  // decode
  tmid_pkg::phase_t e_phase, n_phase;
  logic [31:0]      e_accum, n_accum, e_pend, n_pend;
  logic [3:0]       e_chan, n_chan;
  logic [7:0]       e_prev_note, n_prev_note, e_hcmd, n_hcmd, e_harg, n_harg;
  logic             e_closed, n_closed;
  logic             p_flush1, p_close, p_bad;
  logic [PW-1:0]    p_evt_len;
  logic [7:0]       evt_v [tmid_pkg::EVT_MAX];
  logic [7:0]       note_stat;

  always_comb begin
    e_phase     = in_track_start ? tmid_pkg::PH_DELTA : phase_r;
    e_accum     = in_track_start ? 32'd0 : accum_r;
    e_pend      = in_track_start ? 32'd0 : pend_r;
    e_chan      = in_track_start ? 4'd0 : chan_r;
    e_prev_note = in_track_start ? tmid_pkg::NO_NOTE : prev_note_r;
    e_hcmd      = in_track_start ? 8'd0 : hcmd_r;
    e_harg      = in_track_start ? 8'd0 : harg_r;
    e_closed    = in_track_start ? 1'b0 : closed_r;

    n_phase     = e_phase;
    n_accum     = e_accum;
    n_pend      = e_pend;
    n_chan      = e_chan;
    n_prev_note = e_prev_note;
    n_hcmd      = e_hcmd;
    n_harg      = e_harg;
    n_closed    = e_closed;
    p_flush1    = 1'b0;
    p_close     = 1'b0;
    p_bad       = 1'b0;
    p_evt_len   = '0;
    for (int i = 0; i < tmid_pkg::EVT_MAX; i++) begin
      evt_v[i] = 8'd0;
    end
    note_stat = {tmid_pkg::STAT_NOTE, e_chan};

    if (!e_closed) begin
      case (e_phase) inside
        tmid_pkg::PH_DELTA: begin
          n_accum = {e_accum[24:0], in_byte[6:0]};
          if (!in_byte[7]) begin
            n_pend  = e_pend + n_accum;
            n_accum = 32'd0;
            n_phase = tmid_pkg::PH_EVENT;
          end
        end
        tmid_pkg::PH_EVENT: begin
          if (!in_byte[7]) begin
            n_harg  = in_byte;
            n_phase = tmid_pkg::PH_VEL;
          end else if (in_byte[7:4] == tmid_pkg::CHAN_SEL_HI) begin
            n_chan  = in_byte[3:0];
            n_phase = tmid_pkg::PH_DELTA;
          end else begin
            unique case (in_byte) inside
              tmid_pkg::CMD_NOTE_OFF, tmid_pkg::CMD_PROGRAM, tmid_pkg::CMD_BEND,
              tmid_pkg::CMD_VOLUME, tmid_pkg::CMD_DRUM, tmid_pkg::CMD_PAN,
              tmid_pkg::CMD_CTRL: begin
                n_hcmd  = in_byte;
                n_phase = tmid_pkg::PH_ARG1;
              end
              tmid_pkg::CMD_TRACK_END, tmid_pkg::CMD_LOOP_BACK: begin
                p_close = 1'b1;
              end
              tmid_pkg::CMD_LAST_OFF: begin
                if (e_prev_note != tmid_pkg::NO_NOTE) begin
                  p_flush1    = 1'b1;
                  evt_v[0]    = note_stat;
                  evt_v[1]    = e_prev_note;
                  evt_v[2]    = 8'd0;
                  p_evt_len   = PW'(3);
                  n_prev_note = tmid_pkg::NO_NOTE;
                end
                n_phase = tmid_pkg::PH_DELTA;
              end
              tmid_pkg::CMD_LOOP_START: begin
                n_phase = tmid_pkg::PH_DELTA;
              end
              default: begin
                p_close = 1'b1;
                p_bad   = 1'b1;
              end
            endcase
          end
        end
        tmid_pkg::PH_VEL: begin
          n_phase  = tmid_pkg::PH_DELTA;
          p_flush1 = 1'b1;
          // same note struck again: note-off at delta zero first
          if (e_prev_note == e_harg) begin
            evt_v[0]  = note_stat;
            evt_v[1]  = e_harg;
            evt_v[2]  = 8'd0;
            evt_v[3]  = 8'd0;
            evt_v[4]  = note_stat;
            evt_v[5]  = e_harg;
            evt_v[6]  = in_byte;
            p_evt_len = PW'(7);
          end else begin
            evt_v[0]  = note_stat;
            evt_v[1]  = e_harg;
            evt_v[2]  = in_byte;
            p_evt_len = PW'(3);
          end
          n_prev_note = e_harg;
        end
        tmid_pkg::PH_ARG1, tmid_pkg::PH_ARG2: begin
          if (e_hcmd == tmid_pkg::CMD_CTRL && e_phase == tmid_pkg::PH_ARG1) begin
            n_harg  = in_byte;
            n_phase = tmid_pkg::PH_ARG2;
          end else begin
            n_phase   = tmid_pkg::PH_DELTA;
            p_flush1  = 1'b1;
            p_evt_len = PW'(3);
            evt_v[0]  = {tmid_pkg::STAT_CTRL, e_chan};
            evt_v[1]  = e_harg;
            evt_v[2]  = in_byte;
            unique case (e_hcmd)
              tmid_pkg::CMD_NOTE_OFF: begin
                evt_v[0] = note_stat;
                evt_v[1] = in_byte;
                evt_v[2] = 8'd0;
              end
              tmid_pkg::CMD_PROGRAM: begin
                evt_v[0]  = {tmid_pkg::STAT_PROGRAM, e_chan};
                evt_v[1]  = in_byte;
                p_evt_len = PW'(2);
              end
              tmid_pkg::CMD_BEND: begin
                evt_v[0] = {tmid_pkg::STAT_BEND, e_chan};
                evt_v[1] = 8'd0;
              end
              tmid_pkg::CMD_VOLUME: evt_v[1] = tmid_pkg::CC_VOLUME;
              tmid_pkg::CMD_DRUM:   evt_v[1] = tmid_pkg::CC_DRUM;
              tmid_pkg::CMD_PAN:    evt_v[1] = tmid_pkg::CC_PAN;
              default: ;
            endcase
          end
        end
        default: begin
          n_phase = tmid_pkg::PH_DELTA;
        end
      endcase

      // end of source closes an open track after the byte is used
      if (in_source_last) begin
        p_close = 1'b1;
      end
      if (p_close) begin
        n_closed = 1'b1;
        n_phase  = tmid_pkg::PH_DELTA;
        n_accum  = 32'd0;
      end
    end
  end

  // tempo divider: restoring, one quotient bit per step
  logic [7:0]    bpm_eff;
  logic [DW-1:0] div_idx;
  logic [8:0]    rem_sh;
  logic          rem_ge;
  logic [23:0]   tempo_us;

  always_comb begin
    bpm_eff  = (tempo_r == 8'd0) ? tmid_pkg::TEMPO_DEFAULT : tempo_r;
    div_idx  = DW'(QW - 1) - div_cnt_r;
    rem_sh   = {rem_r, tmid_pkg::TEMPO_DIVIDEND[div_idx]};
    rem_ge   = (rem_sh >= {1'b0, bpm_eff});
    tempo_us = (quo_r[QW-1:24] != '0) ? tmid_pkg::LEN_MAX : quo_r[23:0];
  end

  // VLQ delta writer
  logic [PW-1:0] groups_m1;
  logic [PW-1:0] grp;
  logic [7:0]    vlq_byte;

  always_comb begin
    if (pend_r[31:28] != '0)      groups_m1 = PW'(4);
    else if (pend_r[27:21] != '0) groups_m1 = PW'(3);
    else if (pend_r[20:14] != '0) groups_m1 = PW'(2);
    else if (pend_r[13:7] != '0)  groups_m1 = PW'(1);
    else                          groups_m1 = PW'(0);
    grp = groups_m1 - pos_r;
    case (grp)
      3'd0:    vlq_byte = {1'b0, pend_r[6:0]};
      3'd1:    vlq_byte = {1'b1, pend_r[13:7]};
      3'd2:    vlq_byte = {1'b1, pend_r[20:14]};
      3'd3:    vlq_byte = {1'b1, pend_r[27:21]};
      default: vlq_byte = {4'b1000, pend_r[31:28]};
    endcase
  end

  // byte selection by segment
  logic [7:0]  emit_byte;
  logic        seg_final;
  logic        seg_flush;
  logic        seg_close;
  logic [23:0] count_inc;

  always_comb begin
    emit_byte = 8'd0;
    seg_final = 1'b0;
    seg_flush = 1'b0;
    seg_close = 1'b0;
    unique case (cmd.seg)
      tmid_pkg::C_TEMPO: begin
        seg_final = (pos_r == tmid_pkg::TEMPO_LAST);
        case (pos_r)
          3'd0:    emit_byte = 8'd0;
          3'd1:    emit_byte = tmid_pkg::META;
          3'd2:    emit_byte = tmid_pkg::META_TEMPO;
          3'd3:    emit_byte = tmid_pkg::META_TEMPO_LEN;
          3'd4:    emit_byte = tempo_us[23:16];
          3'd5:    emit_byte = tempo_us[15:8];
          3'd6:    emit_byte = tempo_us[7:0];
          default: emit_byte = 8'd0;
        endcase
      end
      tmid_pkg::C_FLUSH1, tmid_pkg::C_FLUSH2: begin
        seg_flush = 1'b1;
        seg_close = (cmd.seg == tmid_pkg::C_FLUSH2);
        seg_final = (pos_r == groups_m1);
        emit_byte = vlq_byte;
      end
      tmid_pkg::C_EVT: begin
        seg_final = (pos_r == evt_len_r - PW'(1));
        emit_byte = evt_r[pos_r];
      end
      tmid_pkg::C_END: begin
        seg_close = 1'b1;
        seg_final = (pos_r == tmid_pkg::END_LAST);
        case (pos_r)
          3'd0:    emit_byte = tmid_pkg::META;
          3'd1:    emit_byte = tmid_pkg::META_EOT;
          default: emit_byte = 8'd0;
        endcase
      end
      default: ;
    endcase
    count_inc = (count_r == tmid_pkg::LEN_MAX) ? count_r : count_r + 24'd1;
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tempo_r     <= tmid_pkg::TEMPO_DEFAULT;
      phase_r     <= tmid_pkg::PH_DELTA;
      accum_r     <= 32'd0;
      pend_r      <= 32'd0;
      chan_r      <= 4'd0;
      prev_note_r <= tmid_pkg::NO_NOTE;
      hcmd_r      <= 8'd0;
      harg_r      <= 8'd0;
      closed_r    <= 1'b0;
      count_r     <= 24'd0;
      tempo_en_r  <= 1'b0;
      flush1_r    <= 1'b0;
      close_r     <= 1'b0;
      bad_r       <= 1'b0;
      evt_len_r   <= '0;
      pos_r       <= '0;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        tempo_r <= cfg_data;
      end
      if (cmd.accept) begin
        phase_r     <= n_phase;
        accum_r     <= n_accum;
        pend_r      <= n_pend;
        chan_r      <= n_chan;
        prev_note_r <= n_prev_note;
        hcmd_r      <= n_hcmd;
        harg_r      <= n_harg;
        closed_r    <= n_closed;
        tempo_en_r  <= in_track_start & in_first_track;
        flush1_r    <= p_flush1;
        close_r     <= p_close;
        bad_r       <= p_bad;
        evt_len_r   <= p_evt_len;
        div_cnt_r   <= '0;
        if (in_track_start) begin
          count_r <= 24'd0;
        end
      end else if (cmd.div_step) begin
        div_cnt_r <= div_cnt_r + DW'(1);
      end
      if (cmd.emit) begin
        count_r <= count_inc;
        // delta is consumed once written
        if (seg_flush && seg_final) begin
          pend_r <= 32'd0;
        end
      end
      if (cmd.accept || cmd.pos_clr) begin
        pos_r <= '0;
      end else if (cmd.emit) begin
        pos_r <= pos_r + PW'(1);
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      for (int i = 0; i < tmid_pkg::EVT_MAX; i++) begin
        evt_r[i] <= evt_v[i];
      end
      rem_r <= 8'd0;
      quo_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= rem_ge ? 8'(rem_sh - {1'b0, bpm_eff}) : rem_sh[7:0];
      quo_r <= {quo_r[QW-2:0], rem_ge};
    end
    if (cmd.emit) begin
      out_byte_r <= emit_byte;
      out_last_r <= cmd.last;
      out_done_r <= (cmd.seg == tmid_pkg::C_END) && seg_final;
      out_len_r  <= count_inc;
      out_bad_r  <= bad_r && seg_close;
    end
  end

  always_comb begin
    st.tempo_en  = tempo_en_r;
    st.flush1_en = flush1_r;
    st.evt_en    = (evt_len_r != '0);
    st.close_en  = close_r;
    st.div_last  = (div_cnt_r == DW'(QW - 1));
    st.seg_final = seg_final;
    st.out_free  = !out_valid_r || out_ready;
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_last_of_run = out_last_r;
  assign out_track_done  = out_done_r;
  assign out_body_length = out_len_r;
  assign out_bad_command = out_bad_r;

endmodule

`default_nettype wire

// ===== verif/tmid_stream_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmid_stream_checker
// Watches the source and body channels of the tune-to-MIDI block, predicts
// the body bytes of every accepted source beat and compares them in order.
// ----------------------------------------------------------------------------
module tmid_stream_checker
  import tmid_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic [7:0] cfg_data,
  tmid_in_if   in_mon,
  tmid_out_if  out_mon,
  output int   fail_count,
  output int   expect_left,
  output int   beats_in,
  output int   beats_out,
  output int   tracks_closed,
  output int   bad_closes
);

  localparam int RUN_MAX    = 16;
  localparam int REPORT_MAX = 100;

  typedef struct {
    logic [7:0]  data;
    logic        run_last;
    logic        done;
    logic [23:0] len;
    logic        bad;
  } body_beat_t;

  body_beat_t  body_due[$];
  body_beat_t  run_q[$];

  // predicted block state
  logic [7:0]  bpm_setting = TEMPO_DEFAULT;
  phase_t      phase       = PH_DELTA;
  logic [31:0] delta_acc   = '0;
  logic [31:0] delta_due   = '0;
  logic [3:0]  chan        = '0;
  logic [7:0]  prev_note   = NO_NOTE;
  logic [7:0]  held_cmd    = '0;
  logic [7:0]  held_arg    = '0;
  bit          closed      = 1'b0;
  logic [23:0] body_len    = '0;

  int errors  = 0;
  int n_in    = 0;
  int n_out   = 0;
  int n_close = 0;
  int n_bad   = 0;

  function automatic void put_byte(logic [7:0] b, logic done, logic bad);
    body_beat_t e;
    if (run_q.size() >= RUN_MAX) return;
    if (body_len != LEN_MAX) body_len = body_len + 1'b1;
    e.data     = b;
    e.run_last = 1'b0;
    e.done     = done;
    e.len      = body_len;
    e.bad      = bad;
    run_q.push_back(e);
  endfunction

  // pending delta as a big-endian variable-length quantity
  function automatic void put_delta(logic bad);
    int         groups;
    logic [7:0] g;
    groups = 1;
    while (groups < 5 && (delta_due >> (7 * groups)) != 0) groups++;
    for (int i = groups - 1; i >= 0; i--) begin
      g = {1'b0, 7'(delta_due >> (7 * i))};
      if (i > 0) g[7] = 1'b1;
      put_byte(g, 1'b0, bad);
    end
    delta_due = '0;
  endfunction

  function automatic void close_track(logic bad);
    put_delta(bad);
    put_byte(META, 1'b0, bad);
    put_byte(META_EOT, 1'b0, bad);
    put_byte(8'h00, 1'b1, bad);
    closed    = 1'b1;
    phase     = PH_DELTA;
    delta_acc = '0;
  endfunction

  function automatic void new_track();
    phase     = PH_DELTA;
    delta_acc = '0;
    delta_due = '0;
    chan      = '0;
    prev_note = NO_NOTE;
    held_cmd  = '0;
    held_arg  = '0;
    closed    = 1'b0;
    body_len  = '0;
  endfunction

  function automatic void put_tempo();
    logic [7:0]  bpm;
    logic [31:0] usec;
    bpm  = (bpm_setting == 8'd0) ? TEMPO_DEFAULT : bpm_setting;
    usec = 32'(TEMPO_DIVIDEND) / 32'(bpm);
    if (usec > 32'(LEN_MAX)) usec = 32'(LEN_MAX);
    put_byte(8'h00, 1'b0, 1'b0);
    put_byte(META, 1'b0, 1'b0);
    put_byte(META_TEMPO, 1'b0, 1'b0);
    put_byte(META_TEMPO_LEN, 1'b0, 1'b0);
    put_byte(usec[23:16], 1'b0, 1'b0);
    put_byte(usec[15:8], 1'b0, 1'b0);
    put_byte(usec[7:0], 1'b0, 1'b0);
  endfunction

  function automatic void run_command(logic [7:0] b);
    case (b)
      CMD_NOTE_OFF, CMD_PROGRAM, CMD_BEND, CMD_VOLUME, CMD_DRUM, CMD_PAN, CMD_CTRL: begin
        held_cmd = b;
        phase    = PH_ARG1;
      end
      CMD_TRACK_END, CMD_LOOP_BACK: close_track(1'b0);
      CMD_LAST_OFF: begin
        if (prev_note != NO_NOTE) begin
          put_delta(1'b0);
          put_byte({STAT_NOTE, chan}, 1'b0, 1'b0);
          put_byte(prev_note, 1'b0, 1'b0);
          put_byte(8'h00, 1'b0, 1'b0);
          prev_note = NO_NOTE;
        end
        phase = PH_DELTA;
      end
      CMD_LOOP_START: phase = PH_DELTA;
      default: close_track(1'b1);
    endcase
  endfunction

  function automatic void run_arg(logic [7:0] b);
    logic [7:0] cc;
    // generic controller takes its number first, then the value
    if (held_cmd == CMD_CTRL && phase == PH_ARG1) begin
      held_arg = b;
      phase    = PH_ARG2;
      return;
    end
    phase = PH_DELTA;
    put_delta(1'b0);
    case (held_cmd)
      CMD_NOTE_OFF: begin
        put_byte({STAT_NOTE, chan}, 1'b0, 1'b0);
        put_byte(b, 1'b0, 1'b0);
        put_byte(8'h00, 1'b0, 1'b0);
      end
      CMD_PROGRAM: begin
        put_byte({STAT_PROGRAM, chan}, 1'b0, 1'b0);
        put_byte(b, 1'b0, 1'b0);
      end
      CMD_BEND: begin
        put_byte({STAT_BEND, chan}, 1'b0, 1'b0);
        put_byte(8'h00, 1'b0, 1'b0);
        put_byte(b, 1'b0, 1'b0);
      end
      default: begin
        case (held_cmd)
          CMD_VOLUME: cc = CC_VOLUME;
          CMD_DRUM:   cc = CC_DRUM;
          CMD_PAN:    cc = CC_PAN;
          default:    cc = held_arg;
        endcase
        put_byte({STAT_CTRL, chan}, 1'b0, 1'b0);
        put_byte(cc, 1'b0, 1'b0);
        put_byte(b, 1'b0, 1'b0);
      end
    endcase
  endfunction

  function automatic void take_byte(logic [7:0] b);
    case (phase)
      PH_DELTA: begin
        delta_acc = {delta_acc[24:0], b[6:0]};
        if (!b[7]) begin
          delta_due = delta_due + delta_acc;
          delta_acc = '0;
          phase     = PH_EVENT;
        end
      end
      PH_EVENT: begin
        if (!b[7]) begin
          held_arg = b;
          phase    = PH_VEL;
        end else if (b[7:4] == CHAN_SEL_HI) begin
          chan  = b[3:0];
          phase = PH_DELTA;
        end else begin
          run_command(b);
        end
      end
      PH_VEL: begin
        phase = PH_DELTA;
        put_delta(1'b0);
        // striking the same note again: note-off first, then delta zero
        if (prev_note == held_arg) begin
          put_byte({STAT_NOTE, chan}, 1'b0, 1'b0);
          put_byte(held_arg, 1'b0, 1'b0);
          put_byte(8'h00, 1'b0, 1'b0);
          put_byte(8'h00, 1'b0, 1'b0);
        end
        prev_note = held_arg;
        put_byte({STAT_NOTE, chan}, 1'b0, 1'b0);
        put_byte(held_arg, 1'b0, 1'b0);
        put_byte(b, 1'b0, 1'b0);
      end
      PH_ARG1, PH_ARG2: run_arg(b);
      default: phase = PH_DELTA;
    endcase
  endfunction

  // body bytes caused by one source beat
  function automatic void translate_beat(logic [7:0] b, logic start, logic first,
                                         logic last);
    run_q.delete();
    if (start) begin
      new_track();
      if (first) put_tempo();
    end
    if (!closed) begin
      take_byte(b);
      if (last && !closed) close_track(1'b0);
    end
    if (run_q.size() > 0) run_q[$].run_last = 1'b1;
    foreach (run_q[i]) body_due.push_back(run_q[i]);
  endfunction

  function automatic void check_field(string what, logic [23:0] want, logic [23:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= REPORT_MAX)
        $display("%0t: body byte %0d %s expected 0x%0h got 0x%0h",
                 $time, n_out, what, want, got);
    end
  endfunction

  always @(posedge clk) begin : watch
    body_beat_t want;
    if (!rst_n) begin
      bpm_setting = TEMPO_DEFAULT;
      new_track();
      body_due.delete();
    end else begin
      if (cfg_we) bpm_setting = cfg_data;
      if (out_mon.valid && out_mon.ready) begin
        n_out++;
        if (out_mon.track_done) begin
          n_close++;
          if (out_mon.bad_command) n_bad++;
        end
        if (body_due.size() == 0) begin
          errors++;
          if (errors <= REPORT_MAX)
            $display("%0t: body byte %0d expected none got 0x%0h", $time, n_out,
                     out_mon.out_byte);
        end else begin
          want = body_due.pop_front();
          check_field("out_byte", 24'(want.data), 24'(out_mon.out_byte));
          check_field("last_of_run", 24'(want.run_last), 24'(out_mon.last_of_run));
          check_field("track_done", 24'(want.done), 24'(out_mon.track_done));
          check_field("body_length", want.len, out_mon.body_length);
          check_field("bad_command", 24'(want.bad), 24'(out_mon.bad_command));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        n_in++;
        translate_beat(in_mon.in_byte, in_mon.track_start, in_mon.first_track,
                       in_mon.source_last);
      end
    end
    fail_count    <= errors;
    expect_left   <= body_due.size();
    beats_in      <= n_in;
    beats_out     <= n_out;
    tracks_closed <= n_close;
    bad_closes    <= n_bad;
  end

endmodule

// ===== verif/tb_tune_event_to_midi_stream.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tune_event_to_midi_stream
// Feeds source track bytes into the block: a short directed track, then
// random well-formed tracks with truncations, unknown commands and noise,
// under several tempo settings and random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_tune_event_to_midi_stream;
  import tmid_pkg::*;

  localparam int PHASE_BEATS = 40;
  localparam int DRAIN_WAIT  = 40;
  localparam int LONG_HOLD   = 300;
  localparam int STALL_LIMIT = 4000;

  // commands with no meaning below the 0xA0 range
  localparam logic [7:0] ODD_CMDS [5] = '{8'h93, 8'h94, 8'h9A, 8'h9E, 8'h9F};
  localparam logic [7:0] HIGH_CMD_FIRST = 8'hA0;

  typedef struct {
    logic [7:0] data;
    logic       start;
    logic       first;
    logic       last;
  } src_beat_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [7:0] cfg_data;

  tmid_in_if  in_ch ();
  tmid_out_if out_ch ();

  int fail_count;
  int expect_left;
  int beats_in;
  int beats_out;
  int tracks_closed;
  int bad_closes;

  src_beat_t script[$];
  bit        calm      = 1'b0;
  bit        long_hold = 1'b0;

  tune_event_to_midi_stream dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .in_s    (in_ch),
    .out_s   (out_ch)
  );

  tmid_stream_checker body_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count   (fail_count),
    .expect_left  (expect_left),
    .beats_in     (beats_in),
    .beats_out    (beats_out),
    .tracks_closed(tracks_closed),
    .bad_closes   (bad_closes)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void add_src(logic [7:0] b);
    src_beat_t s;
    s.data  = b;
    s.start = 1'b0;
    s.first = ($urandom_range(0, 9) == 0);  // don't care without track start
    s.last  = 1'b0;
    script.push_back(s);
  endfunction

  function automatic void add_delta();
    int pick;
    int groups;
    pick = $urandom_range(0, 99);
    if (pick < 70)      groups = 1;
    else if (pick < 88) groups = 2;
    else if (pick < 96) groups = $urandom_range(3, 4);
    else                groups = 5;
    repeat (groups - 1) add_src(8'($urandom_range(8'h80, 8'hFF)));
    add_src(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 8'h7F)));
  endfunction

  function automatic void add_event();
    int         pick;
    logic [7:0] note;
    pick = $urandom_range(0, 19);
    // a narrow pool of notes makes re-triggers common
    note = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 8'h7F))
                                       : 8'($urandom_range(8'h3C, 8'h3E));
    if (pick < 8) begin
      add_src(note);
      add_src(8'($urandom));
    end else begin
      case (pick)
        8, 19: add_src({CHAN_SEL_HI, 4'($urandom)});
        9:  begin add_src(CMD_NOTE_OFF); add_src(note); end
        10: begin add_src(CMD_PROGRAM);  add_src(8'($urandom)); end
        11: begin add_src(CMD_BEND);     add_src(8'($urandom)); end
        12: begin add_src(CMD_VOLUME);   add_src(8'($urandom)); end
        13: begin add_src(CMD_DRUM);     add_src(8'($urandom)); end
        14: begin add_src(CMD_PAN);      add_src(8'($urandom)); end
        15, 18: add_src(CMD_LAST_OFF);
        16: add_src(CMD_LOOP_START);
        default: begin
          add_src(CMD_CTRL);
          add_src(8'($urandom));
          add_src(8'($urandom));
        end
      endcase
    end
  endfunction

  function automatic void add_track(logic first);
    int head;
    int tail;
    int cut;
    int pick;
    head = script.size();
    repeat ($urandom_range(1, 8)) begin
      add_delta();
      add_event();
    end
    script[head].start = 1'b1;
    script[head].first = first;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      add_delta();
      add_src(CMD_TRACK_END);
      if ($urandom_range(0, 4) == 0) script[$].last = 1'b1;
    end else if (pick < 42) begin
      add_delta();
      add_src(CMD_LOOP_BACK);
    end else if (pick < 57) begin
      add_delta();
      if ($urandom_range(0, 1) == 0) add_src(ODD_CMDS[$urandom_range(0, 4)]);
      else add_src(8'($urandom_range(HIGH_CMD_FIRST, 8'hFF)));
    end else if (pick < 75) begin
      // source ends inside a delta or an event
      tail = script.size();
      add_delta();
      add_event();
      cut = $urandom_range(tail, script.size() - 1);
      while (script.size() > cut + 1) void'(script.pop_back());
      script[cut].last = 1'b1;
    end else if (pick < 85) begin
      script[$].last = 1'b1;
    end
    // else the track stays open and the next track start abandons it
    if (pick < 85 && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) add_src(8'($urandom));
  endfunction

  task automatic play_script();
    src_beat_t s;
    bit        gaps;
    gaps = 1'b1;
    while (script.size() > 0) begin
      s = script.pop_front();
      if ($urandom_range(0, 39) == 0) gaps = !gaps;
      if (!calm && gaps && $urandom_range(0, 6) == 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      in_ch.valid       <= 1'b1;
      in_ch.in_byte     <= s.data;
      in_ch.track_start <= s.start;
      in_ch.first_track <= s.first;
      in_ch.source_last <= s.last;
      do @(posedge clk); while (in_ch.ready !== 1'b1);
    end
    in_ch.valid <= 1'b0;
  endtask

  // wait for every predicted byte, then for a beat that made none
  task automatic drain();
    @(posedge clk);
    while (expect_left != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic set_tempo(logic [7:0] bpm);
    cfg_we   <= 1'b1;
    cfg_data <= bpm;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  initial begin : stimulus
    logic [7:0] tempo_plan [$];
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_data          <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.in_byte     <= '0;
    in_ch.track_start <= 1'b0;
    in_ch.first_track <= 1'b0;
    in_ch.source_last <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // no track start yet: parsed as a track without tempo
    add_src(8'h00); add_src(8'h3C); add_src(8'h40);
    add_src(8'h00); add_src(8'h3C); add_src(8'h7F);
    add_src(8'h81); add_src(8'h00); add_src(CMD_LAST_OFF);
    add_src(8'h00); add_src(CMD_LAST_OFF);
    add_src(8'h00); add_src({CHAN_SEL_HI, 4'hF});
    add_src(8'h00); add_src(CMD_CTRL); add_src(8'h00); add_src(8'hFF);
    // five-group delta wraps the accumulator
    add_src(8'hFF); add_src(8'hFF); add_src(8'hFF); add_src(8'hFF); add_src(8'h7F);
    add_src(CMD_TRACK_END);
    add_src(8'h55);
    add_track(1'b1);
    while (script.size() < PHASE_BEATS + 24) add_track(1'b0);
    play_script();

    tempo_plan = '{8'd0, 8'd1, 8'd3, 8'd4, 8'd255,
                   8'($urandom_range(5, 254)), 8'($urandom)};
    foreach (tempo_plan[i]) begin
      drain();
      set_tempo(tempo_plan[i]);
      if (i == 1) long_hold = 1'b1;
      if (i == tempo_plan.size() - 1) calm = 1'b1;
      add_track(1'b1);
      while (script.size() < PHASE_BEATS) add_track($urandom_range(0, 5) == 0);
      play_script();
    end
    drain();

    $display("summary: %0d source beats, %0d body bytes, %0d tracks closed (%0d on bad commands)",
             beats_in, beats_out, tracks_closed, bad_closes);
    $display("summary: tempo at reset value, 0, 1, 3, 4, 255 and random; one long output hold-off");
    if (fail_count == 0 && expect_left == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : body_sink
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold) begin
        // block fills up while the source keeps offering
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold = 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
